### design/fpsp_pkg.sv
// Package with payload types and format codes for the float to PCM sample packer.
package fpsp_pkg;

	typedef enum logic [2:0] {
		FMT_INT16      = 3'd0,
		FMT_INT24      = 3'd1,
		FMT_INT24_IN32 = 3'd2,
		FMT_INT32      = 3'd3,
		FMT_FLOAT32    = 3'd4
	} sample_fmt_t;

	typedef struct packed {
		logic [31:0] sample_bits;
		logic [2:0]  sample_format;
	} in_item_t;

	typedef struct packed {
		logic [31:0] packed_word;
		logic [2:0]  byte_count;
	} out_item_t;

	localparam logic [2:0] COUNT_2 = 3'd2;
	localparam logic [2:0] COUNT_3 = 3'd3;
	localparam logic [2:0] COUNT_4 = 3'd4;

endpackage

### design/float_to_pcm_sample_packer.sv
// Float to PCM sample packer: one sample per cycle, one input and one output register.
// Each transfer on the input is registered, converted by the logic between the
// registers and loaded into the output register once that is empty or not stalled.
// The block accepts one sample every clock while the output is not
// stalled; the input stalls only when both registers are full and the output is stalled.
// The path between the registers is a 6-bit-amount shift of the mantissa plus one 33-bit
// increment and a negate.
module float_to_pcm_sample_packer
	import fpsp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic     v_s1;
	in_item_t d_s1;
	logic     adv_s1;
	logic     load_out;

	assign load_out = v_s1 && (!out_valid || !out_stall);
	assign adv_s1   = !v_s1 || load_out;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			d_s1 <= in_data;
		end
	end

	// Conversion datapath.
	logic        sgn;
	logic [7:0]  expo;
	logic [22:0] frac;
	logic        is_nan;
	logic [5:0]  fbits;      // scale exponent: 15, 23 or 31
	logic [31:0] mag;        // truncated magnitude after scaling
	logic        rnd;        // first bit dropped by the shift
	logic [32:0] mag_r;
	logic [31:0] pos_max;
	logic [32:0] mag_sat;
	logic [32:0] val;
	logic [55:0] m_ext;
	logic [8:0]  shamt;
	logic [31:0] word;
	logic [2:0]  cnt;

	assign sgn    = d_s1.sample_bits[31];
	assign expo   = d_s1.sample_bits[30:23];
	assign frac   = d_s1.sample_bits[22:0];
	assign is_nan = (expo == 8'hFF) && (frac != 23'd0);

	always_comb begin
		case (d_s1.sample_format)
			FMT_INT16: fbits = 6'd15;
			FMT_INT24, FMT_INT24_IN32: fbits = 6'd23;
			default: fbits = 6'd31;
		endcase
		pos_max = (32'h1 << fbits[4:0]) - 32'd1;
		// Value = 1.frac * 2^(expo-127) * 2^fbits. Place the leading one so that
		// bit 24 of m_ext is the units bit: shift left by expo-127+fbits from a
		// word holding 1.frac with 24 fraction bits.
		m_ext = '0;
		mag   = '0;
		rnd   = 1'b0;
		shamt = 9'({1'b0, expo}) + 9'(fbits) - 9'd127;
		if (expo >= 8'd127) begin
			// Magnitude at least one: clamp, equals the scale itself.
			mag = 32'h1 << fbits[4:0];
		end else if (expo == 8'd0) begin
			// Zero and subnormals round to zero at every scale.
			mag = '0;
		end else if ({1'b0, expo} + 9'(fbits) >= 9'd127) begin
			// Exponent in range: shamt in 0..fbits-1, shift within 56 bits.
			m_ext = 56'({1'b1, frac, 1'b0}) << shamt[5:0];
			mag   = 32'(m_ext[55:24]);
			rnd   = m_ext[23];
		end else if ({1'b0, expo} + 9'(fbits) == 9'd126) begin
			// The scaled magnitude lies in [0.5, 1), which rounds away from zero to one.
			rnd = 1'b1;
		end
		mag_r   = {1'b0, mag} + 33'(rnd);
		mag_sat = (!sgn && mag_r > {1'b0, pos_max}) ? {1'b0, pos_max} : mag_r;
		val     = sgn ? (33'd0 - mag_sat) : mag_sat;
		if (is_nan) val = '0;
		case (d_s1.sample_format)
			FMT_INT16: begin
				word = {16'd0, val[15:0]};
				cnt  = COUNT_2;
			end
			FMT_INT24: begin
				word = {8'd0, val[23:0]};
				cnt  = COUNT_3;
			end
			FMT_INT24_IN32: begin
				word = {val[23:0], 8'd0};
				cnt  = COUNT_4;
			end
			FMT_INT32: begin
				word = val[31:0];
				cnt  = COUNT_4;
			end
			default: begin
				word = d_s1.sample_bits;
				cnt  = COUNT_4;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || !out_stall) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data.packed_word <= word;
			out_data.byte_count  <= cnt;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.byte_count == COUNT_2 || out_data.byte_count == COUNT_3
			|| out_data.byte_count == COUNT_4))
		else $error("bad byte count");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && out_valid && out_stall)
		else $error("input stalled without cause");

endmodule

### sim/testbench.sv
// Self-checking testbench for the float to PCM sample packer.
`timescale 1ns / 100ps

module testbench;
	import fpsp_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_ITEMS = 1330;
	localparam int CALM_ITEMS = 200;

	typedef struct {
		logic [31:0] bits;
		logic [2:0]  fmt;
		bit          typed;
		logic [31:0] word;
		logic [2:0]  count;
	} table_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;

	out_item_t pcm_expected[$];
	int        errors = 0;
	int        sent = 0;
	int        cycles = 0;
	bit        calm = 0;
	bit        held_long = 0;

	float_to_pcm_sample_packer uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Scale by 2^n_bits, round half away from zero and saturate, all in exact integer terms.
	function automatic logic [63:0] scale_sample(logic [31:0] bits, int n_bits);
		logic [7:0]  e;
		logic [63:0] sig;
		logic [63:0] mag;
		int          unb;
		int          sh;
		logic [63:0] hi;
		e = bits[30:23];
		hi = (64'd1 << n_bits) - 1;
		if (e == 8'hFF && bits[22:0] != 0)
			return 64'd0;
		if (e >= 8'd127) begin
			mag = hi + 1;
		end else begin
			sig = (e == 0) ? {41'd0, bits[22:0]} : {40'd0, 1'b1, bits[22:0]};
			unb = (e == 0) ? -126 : int'(e) - 127;
			sh = unb - 23 + n_bits;
			if (sh >= 0)
				mag = sig << sh;
			else if (-sh > 40)
				mag = 0;
			else
				mag = (sig >> (-sh)) + ((sig >> (-sh - 1)) & 64'd1);
		end
		if (bits[31])
			return -mag;
		if (mag > hi)
			mag = hi;
		return mag;
	endfunction

	function automatic out_item_t pack_pcm(logic [31:0] bits, logic [2:0] fmt);
		out_item_t   r;
		logic [63:0] v;
		case (fmt)
			FMT_INT16: begin
				v = scale_sample(bits, 15);
				r.packed_word = {16'd0, v[15:0]};
				r.byte_count = COUNT_2;
			end
			FMT_INT24: begin
				v = scale_sample(bits, 23);
				r.packed_word = {8'd0, v[23:0]};
				r.byte_count = COUNT_3;
			end
			FMT_INT24_IN32: begin
				v = scale_sample(bits, 23);
				r.packed_word = {v[23:0], 8'd0};
				r.byte_count = COUNT_4;
			end
			FMT_INT32: begin
				v = scale_sample(bits, 31);
				r.packed_word = v[31:0];
				r.byte_count = COUNT_4;
			end
			default: begin
				r.packed_word = bits;
				r.byte_count = COUNT_4;
			end
		endcase
		return r;
	endfunction

	// Offers one sample and waits for its transfer; the expectation is queued on acceptance.
	task automatic send_sample(logic [31:0] bits, logic [2:0] fmt, bit typed, out_item_t want);
		int        gap;
		out_item_t exp_item;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			gap = $urandom_range(1, 14);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		in_data.sample_bits <= bits;
		in_data.sample_format <= fmt;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		exp_item = typed ? want : pack_pcm(bits, fmt);
		pcm_expected.insert(pcm_expected.size(), exp_item);
		sent++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] random_float();
		logic [31:0] b;
		b = $urandom;
		case ($urandom_range(0, 7))
			0, 1: ;
			2: b[30:23] = 8'd127;
			3: b[30:23] = 8'hFF;
			4: b[30:23] = 8'd0;
			default: b[30:23] = $urandom_range(96, 126);
		endcase
		return b;
	endfunction

	initial begin
		table_row_t  rows[$];
		out_item_t   want;
		logic [2:0]  fmt;
		in_valid = 0;
		in_data = '0;
		arst_n = 0;
		rows = '{
			'{32'h00000000, FMT_INT16, 1, 32'h00000000, COUNT_2},
			'{32'h80000000, FMT_INT32, 1, 32'h00000000, COUNT_4},
			'{32'h3F800000, FMT_INT16, 1, 32'h00007FFF, COUNT_2},
			'{32'hBF800000, FMT_INT16, 1, 32'h00008000, COUNT_2},
			'{32'h3F800000, FMT_INT24, 1, 32'h007FFFFF, COUNT_3},
			'{32'hBF800000, FMT_INT24_IN32, 1, 32'h80000000, COUNT_4},
			'{32'h3F800000, FMT_INT24_IN32, 1, 32'h7FFFFF00, COUNT_4},
			'{32'h3F800000, FMT_INT32, 1, 32'h7FFFFFFF, COUNT_4},
			'{32'hBF800000, FMT_INT32, 1, 32'h80000000, COUNT_4},
			'{32'h7F800000, FMT_INT16, 1, 32'h00007FFF, COUNT_2},
			'{32'hFF800000, FMT_INT24, 1, 32'h00800000, COUNT_3},
			'{32'h40000000, FMT_INT32, 1, 32'h7FFFFFFF, COUNT_4},
			'{32'h7FC00000, FMT_INT16, 1, 32'h00000000, COUNT_2},
			'{32'hFFFFFFFF, FMT_INT32, 1, 32'h00000000, COUNT_4},
			'{32'h7FC00000, FMT_FLOAT32, 1, 32'h7FC00000, COUNT_4},
			'{32'h12345678, 3'd5, 1, 32'h12345678, COUNT_4},
			'{32'hA5A5A5A5, 3'd6, 1, 32'hA5A5A5A5, COUNT_4},
			'{32'hFFFFFFFF, 3'd7, 1, 32'hFFFFFFFF, COUNT_4},
			'{32'h3F000000, FMT_INT16, 1, 32'h00004000, COUNT_2},
			'{32'h37800000, FMT_INT16, 1, 32'h00000001, COUNT_2},
			'{32'hB7800000, FMT_INT16, 1, 32'h0000FFFF, COUNT_2},
			'{32'h3F7FFFFF, FMT_INT16, 0, 32'h0, COUNT_2},
			'{32'h00000001, FMT_INT32, 0, 32'h0, COUNT_4},
			'{32'hBEAAAAAB, FMT_INT24_IN32, 0, 32'h0, COUNT_4}
		};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		foreach (rows[i]) begin
			want.packed_word = rows[i].word;
			want.byte_count = rows[i].count;
			send_sample(rows[i].bits, rows[i].fmt, rows[i].typed, want);
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1;
			fmt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			send_sample(random_float(), fmt, 0, want);
		end
		in_valid <= 0;
		while (pcm_expected.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("float_to_pcm_sample_packer test passed");
		else
			$display("float_to_pcm_sample_packer test failed");
		$finish;
	end

	// Receiver: random stall bursts, plus one long hold-off so the block backs up.
	initial begin
		int hold;
		hold = 0;
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				out_stall <= 1;
			end else if (!calm && !held_long && sent >= 300) begin
				held_long = 1;
				hold = 79;
				out_stall <= 1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(0, 13);
				out_stall <= 1;
			end else begin
				out_stall <= 0;
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("float_to_pcm_sample_packer test failed");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pcm_expected.size() == 0) begin
				$display("%0t: unexpected transfer, expected none, actual word %h count %0d",
					$time, out_data.packed_word, out_data.byte_count);
				errors++;
			end else begin
				want = pcm_expected[0];
				pcm_expected.delete(0);
				if (out_data.packed_word !== want.packed_word) begin
					$display("%0t: packed_word expected %h actual %h",
						$time, want.packed_word, out_data.packed_word);
					errors++;
				end
				if (out_data.byte_count !== want.byte_count) begin
					$display("%0t: byte_count expected %0d actual %0d",
						$time, want.byte_count, out_data.byte_count);
					errors++;
				end
			end
		end
	end

endmodule
